@@ rtl/parabolic_vertex_estimate_macros.svh @@
// Assertion macros used by the parabolic_vertex_estimate module.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef PARABOLIC_VERTEX_ESTIMATE_MACROS_SVH
`define PARABOLIC_VERTEX_ESTIMATE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PVE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PVE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pve_pkg.sv @@
// Shared widths, codes and helper functions for the vertex estimator.
// Used by pve_div and parabolic_vertex_estimate; depends on nothing.
package pve_pkg;

	// Number format and field widths.
	localparam int FRAC_BITS = 16;
	localparam int XW        = 32;
	localparam int DXW       = XW + 1;
	localparam int IN_W      = 6 * XW;
	localparam int OUT_W     = ((XW + 2 + 7) / 8) * 8;

	// Divider geometry: one quotient bit per stage.
	localparam int DIV_QW  = XW + FRAC_BITS;
	localparam int DIV_DW  = DIV_QW + 1;
	localparam int DIV_NW  = DIV_QW + XW + 1;
	localparam int DIV_LAT = DIV_QW + 1;
	localparam int HIW     = DIV_QW - XW;

	// Slope, slope difference and offset widths.
	localparam int SLW      = DIV_QW + 1;
	localparam int DFW      = SLW + 1;
	localparam int CAP_BITS = 34;
	localparam int WMW      = CAP_BITS + 1;
	localparam int WW       = WMW + 1;
	localparam int VW       = WW + 1;
	localparam int X0W      = VW - 1;
	localparam int FBW      = XW + 2;
	localparam logic [DIV_QW-1:0] W_CAP = DIV_QW'(1) << CAP_BITS;

	// Reciprocal of 100 for values below 2^33: floor(m/100) = (m*RCP) >> RCP_SH.
	localparam int RCPW   = 33;
	localparam int RCP_SH = 39;
	localparam int QHW    = 2 * RCPW - RCP_SH;
	localparam logic [RCPW-1:0] RCP      = 33'd5497558139;
	localparam logic [RCPW-1:0] CEIL_ADD = 33'd99;

	// Result kinds.
	localparam logic [1:0] OC_VERTEX = 2'd0;
	localparam logic [1:0] OC_CLAMP  = 2'd1;
	localparam logic [1:0] OC_EQUAL  = 2'd2;
	localparam logic [1:0] OC_NOMAX  = 2'd3;

	// Which point holds the largest y.
	localparam logic [1:0] SEL_SECOND = 2'd0;
	localparam logic [1:0] SEL_FIRST  = 2'd1;
	localparam logic [1:0] SEL_THIRD  = 2'd2;

	// Magnitude of a coordinate difference.
	function automatic logic [DXW-1:0] mag_dx(input logic signed [DXW-1:0] v);
		logic [DXW-1:0] r;
		r = v[DXW-1] ? DXW'(-v) : DXW'(v);
		return r;
	endfunction

	// Saturate to the signed 32-bit range.
	function automatic logic signed [XW-1:0] sat_x(input logic signed [X0W-1:0] v);
		logic signed [XW-1:0] r;
		if (v > X0W'($signed({1'b0, {(XW-1){1'b1}}}))) begin
			r = {1'b0, {(XW-1){1'b1}}};
		end else if (v < X0W'($signed({1'b1, {(XW-1){1'b0}}}))) begin
			r = {1'b1, {(XW-1){1'b0}}};
		end else begin
			r = v[XW-1:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/parabolic_vertex_estimate.sv @@
// Parabolic vertex estimator: takes three (x,y) points in signed Q16.16 and
// proposes the x of the maximum of the parabola through them, with fallbacks
// for equal slopes, a missing maximum or coinciding x values, and a pull-back
// toward lower_bound. It accepts one item every cycle while the output is not
// stalled; m_tvalid for an item rises after 106 register stages. Most of these
// are in two pipelined dividers of 49 register stages each, in series (the
// two slopes, then the vertex offset). The whole pipeline advances together and
// holds only when the output item is not taken.
// Depends on pve_pkg, pve_div and parabolic_vertex_estimate_macros.svh.
module parabolic_vertex_estimate (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       lower_bound_we,
	input  logic [pve_pkg::XW-1:0]     lower_bound_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// first_x, second_x, third_x, first_y, second_y, third_y
	input  logic [pve_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// next_x, outcome, zero fill
	output logic [pve_pkg::OUT_W-1:0]  m_tdata
);
	import pve_pkg::*;

	`include "parabolic_vertex_estimate_macros.svh"

	typedef struct packed {
		logic                  v;
		logic                  coin;
		logic signed [DXW-1:0] sum12;
		logic signed [XW-1:0]  x1;
		logic signed [DXW-1:0] dx23;
		logic                  sg2;
		logic                  sg3;
		logic signed [XW-1:0]  fb2;
		logic signed [FBW-1:0] fb3;
	} sba_t;

	typedef struct packed {
		logic                  v;
		logic                  coin;
		logic                  eq;
		logic                  nomax;
		logic                  neg;
		logic signed [DXW-1:0] sum12;
		logic signed [XW-1:0]  x1;
		logic signed [XW-1:0]  fb2;
		logic signed [FBW-1:0] fb3;
	} sbb_t;

	localparam int SBA_N = DIV_LAT - 1;

	logic adv;
	logic signed [XW-1:0] lower_bound_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_bound_q <= '0;
		end else if (lower_bound_we) begin
			lower_bound_q <= lower_bound_data;
		end
	end

	logic v_s10;
	assign adv      = !v_s10 || m_tready;
	assign s_tready = adv;

	// Stage 1: input register.
	logic v_s1;
	logic signed [XW-1:0] x1_s1, x2_s1, x3_s1, y1_s1, y2_s1, y3_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s1 <= s_tdata[0*XW +: XW];
			x2_s1 <= s_tdata[1*XW +: XW];
			x3_s1 <= s_tdata[2*XW +: XW];
			y1_s1 <= s_tdata[3*XW +: XW];
			y2_s1 <= s_tdata[4*XW +: XW];
			y3_s1 <= s_tdata[5*XW +: XW];
		end
	end

	// Stage 2: differences, best point and magnitudes.
	logic v_s2, coin_s2;
	logic signed [DXW-1:0] dx12_s2, dx13_s2, dx23_s2, dy12_s2, dy13_s2, sum12_s2;
	logic signed [XW-1:0]  x1_s2, x2_s2, x3_s2;
	logic [1:0]            sel_s2;
	logic [XW-1:0]         m1_s2, m3_s2;
	logic signed [XW-1:0]  ybest;
	logic [1:0]            sel_c;

	always_comb begin
		sel_c = SEL_SECOND;
		ybest = y2_s1;
		if (y1_s1 > y2_s1) begin
			sel_c = SEL_FIRST;
			ybest = y1_s1;
		end
		if (y3_s1 > ybest) begin
			sel_c = SEL_THIRD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coin_s2  <= (x1_s1 == x2_s1) || (x1_s1 == x3_s1);
			dx12_s2  <= DXW'(x1_s1) - DXW'(x2_s1);
			dx13_s2  <= DXW'(x1_s1) - DXW'(x3_s1);
			dx23_s2  <= DXW'(x2_s1) - DXW'(x3_s1);
			dy12_s2  <= DXW'(y1_s1) - DXW'(y2_s1);
			dy13_s2  <= DXW'(y1_s1) - DXW'(y3_s1);
			sum12_s2 <= DXW'(x1_s1) + DXW'(x2_s1);
			x1_s2    <= x1_s1;
			x2_s2    <= x2_s1;
			x3_s2    <= x3_s1;
			sel_s2   <= sel_c;
			m1_s2    <= x1_s1[XW-1] ? XW'(-x1_s1) : XW'(x1_s1);
			m3_s2    <= x3_s1[XW-1] ? XW'(-x3_s1) : XW'(x3_s1);
		end
	end

	// Slope dividers: |dy| scaled by 2^FRAC_BITS over |dx|.
	logic [DIV_QW-1:0] qa, qb;
	logic              ovfa, ovfb;

	pve_div u_div_s2 (
		.clk    (clk),
		.en     (adv),
		.num    (DIV_NW'(mag_dx(dy12_s2)) << FRAC_BITS),
		.den    (DIV_DW'(mag_dx(dx12_s2))),
		.quo    (qa),
		.ovf    (ovfa)
	);

	pve_div u_div_s3 (
		.clk    (clk),
		.en     (adv),
		.num    (DIV_NW'(mag_dx(dy13_s2)) << FRAC_BITS),
		.den    (DIV_DW'(mag_dx(dx13_s2))),
		.quo    (qb),
		.ovf    (ovfb)
	);

	// Stage 3: divide the x magnitudes by 100 for the scaled fallback.
	logic v_s3, coin_s3, sg2_s3, sg3_s3;
	logic signed [DXW-1:0] sum12_s3, dx23_s3;
	logic signed [XW-1:0]  x1_s3, x2_s3, x3_s3;
	logic [1:0]            sel_s3;
	logic [XW-1:0]         m1_s3, m3_s3;
	logic [QHW-1:0]        q1_s3, q3_s3;
	logic [2*RCPW-1:0]     prod1, prod3;

	assign prod1 = (2*RCPW)'(RCPW'(m1_s2) + CEIL_ADD) * (2*RCPW)'(RCP);
	assign prod3 = (2*RCPW)'(m3_s2) * (2*RCPW)'(RCP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coin_s3  <= coin_s2;
			sg2_s3   <= dy12_s2[DXW-1] ^ dx12_s2[DXW-1];
			sg3_s3   <= dy13_s2[DXW-1] ^ dx13_s2[DXW-1];
			sum12_s3 <= sum12_s2;
			dx23_s3  <= dx23_s2;
			x1_s3    <= x1_s2;
			x2_s3    <= x2_s2;
			x3_s3    <= x3_s2;
			sel_s3   <= sel_s2;
			m1_s3    <= m1_s2;
			m3_s3    <= m3_s2;
			q1_s3    <= prod1[2*RCPW-1:RCP_SH];
			q3_s3    <= prod3[2*RCPW-1:RCP_SH];
		end
	end

	// Fallback candidates: plain best x and best x with the outer points scaled.
	sba_t sba_in;
	sba_t sba_q [0:SBA_N-1];
	logic [FBW-1:0] sc1_mag, sc3_mag;
	logic signed [FBW-1:0] sc1, sc3;

	always_comb begin
		sc1_mag = FBW'(m1_s3) - FBW'(q1_s3);
		sc3_mag = FBW'(m3_s3) + FBW'(q3_s3);
		sc1     = x1_s3[XW-1] ? -$signed(sc1_mag) : $signed(sc1_mag);
		sc3     = x3_s3[XW-1] ? -$signed(sc3_mag) : $signed(sc3_mag);
		sba_in.v     = v_s3;
		sba_in.coin  = coin_s3;
		sba_in.sum12 = sum12_s3;
		sba_in.x1    = x1_s3;
		sba_in.dx23  = dx23_s3;
		sba_in.sg2   = sg2_s3;
		sba_in.sg3   = sg3_s3;
		case (sel_s3)
			SEL_FIRST: begin
				sba_in.fb2 = x1_s3;
				sba_in.fb3 = sc1;
			end
			SEL_THIRD: begin
				sba_in.fb2 = x3_s3;
				sba_in.fb3 = sc3;
			end
			default: begin
				sba_in.fb2 = x2_s3;
				sba_in.fb3 = FBW'(x2_s3);
			end
		endcase
	end

	// Side line that keeps pace with the slope dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SBA_N; i++) begin
				sba_q[i] <= '0;
			end
		end else if (adv) begin
			sba_q[0] <= sba_in;
			for (int i = 1; i < SBA_N; i++) begin
				sba_q[i] <= sba_q[i-1];
			end
		end
	end

	sba_t sba_o;
	assign sba_o = sba_q[SBA_N-1];

	// Stage 5: signed slopes.
	logic v_s5, coin_s5;
	logic signed [DXW-1:0] sum12_s5, dx23_s5;
	logic signed [XW-1:0]  x1_s5, fb2_s5;
	logic signed [FBW-1:0] fb3_s5;
	logic signed [SLW-1:0] s2_s5, s3_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= sba_o.v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coin_s5  <= sba_o.coin;
			sum12_s5 <= sba_o.sum12;
			dx23_s5  <= sba_o.dx23;
			x1_s5    <= sba_o.x1;
			fb2_s5   <= sba_o.fb2;
			fb3_s5   <= sba_o.fb3;
			s2_s5    <= sba_o.sg2 ? -$signed(SLW'(qa)) : $signed(SLW'(qa));
			s3_s5    <= sba_o.sg3 ? -$signed(SLW'(qb)) : $signed(SLW'(qb));
		end
	end

	// Stage 6: slope difference and offset sign.
	logic v_s6, coin_s6, neg_s6;
	logic signed [DXW-1:0] sum12_s6, dx23_s6;
	logic signed [XW-1:0]  x1_s6, fb2_s6;
	logic signed [FBW-1:0] fb3_s6;
	logic signed [DFW-1:0] d_s6, d_c;
	logic [DIV_QW-1:0]     as2_s6;

	assign d_c = DFW'(s2_s5) - DFW'(s3_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coin_s6  <= coin_s5;
			sum12_s6 <= sum12_s5;
			dx23_s6  <= dx23_s5;
			x1_s6    <= x1_s5;
			fb2_s6   <= fb2_s5;
			fb3_s6   <= fb3_s5;
			d_s6     <= d_c;
			as2_s6   <= s2_s5[SLW-1] ? DIV_QW'(-s2_s5) : DIV_QW'(s2_s5);
			neg_s6   <= (s2_s5[SLW-1] ^ dx23_s5[DXW-1]) ^ d_c[DFW-1];
		end
	end

	// Stage 7: case flags, divisor magnitude and partial products of s2 * dx23.
	logic v_s7, coin_s7, neg_s7, eq_s7, nomax_s7;
	logic signed [DXW-1:0]   sum12_s7;
	logic signed [XW-1:0]    x1_s7, fb2_s7;
	logic signed [FBW-1:0]   fb3_s7;
	logic [DIV_DW-1:0]       ad_s7;
	logic [XW+DXW-1:0]       plo_s7;
	logic [HIW+DXW-1:0]      phi_s7;
	logic [DXW-1:0]          adx23;

	assign adx23 = mag_dx(dx23_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coin_s7  <= coin_s6;
			neg_s7   <= neg_s6;
			eq_s7    <= d_s6 == '0;
			nomax_s7 <= (dx23_s6 == '0) || (d_s6[DFW-1] == dx23_s6[DXW-1]);
			sum12_s7 <= sum12_s6;
			x1_s7    <= x1_s6;
			fb2_s7   <= fb2_s6;
			fb3_s7   <= fb3_s6;
			ad_s7    <= d_s6[DFW-1] ? DIV_DW'(-d_s6) : DIV_DW'(d_s6);
			plo_s7   <= (XW+DXW)'(as2_s6[XW-1:0]) * (XW+DXW)'(adx23);
			phi_s7   <= (HIW+DXW)'(as2_s6[DIV_QW-1:XW]) * (HIW+DXW)'(adx23);
		end
	end

	// Stage 8: full product.
	logic v_s8, coin_s8, neg_s8, eq_s8, nomax_s8;
	logic signed [DXW-1:0]   sum12_s8;
	logic signed [XW-1:0]    x1_s8, fb2_s8;
	logic signed [FBW-1:0]   fb3_s8;
	logic [DIV_DW-1:0]       ad_s8;
	logic [DIV_NW-1:0]       prod_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coin_s8  <= coin_s7;
			neg_s8   <= neg_s7;
			eq_s8    <= eq_s7;
			nomax_s8 <= nomax_s7;
			sum12_s8 <= sum12_s7;
			x1_s8    <= x1_s7;
			fb2_s8   <= fb2_s7;
			fb3_s8   <= fb3_s7;
			ad_s8    <= ad_s7;
			prod_s8  <= (DIV_NW'(phi_s7) << XW) + DIV_NW'(plo_s7);
		end
	end

	// Offset divider: twice the vertex offset, |s2 * dx23| / |d|.
	logic [DIV_QW-1:0] qc;
	logic              ovfc;

	pve_div u_div_w (
		.clk    (clk),
		.en     (adv),
		.num    (prod_s8),
		.den    (ad_s8),
		.quo    (qc),
		.ovf    (ovfc)
	);

	// Side line that keeps pace with the offset divider.
	sbb_t sbb_in;
	sbb_t sbb_q [0:DIV_LAT-1];
	sbb_t sbb_o;

	always_comb begin
		sbb_in.v     = v_s8;
		sbb_in.coin  = coin_s8;
		sbb_in.eq    = eq_s8;
		sbb_in.nomax = nomax_s8;
		sbb_in.neg   = neg_s8;
		sbb_in.sum12 = sum12_s8;
		sbb_in.x1    = x1_s8;
		sbb_in.fb2   = fb2_s8;
		sbb_in.fb3   = fb3_s8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				sbb_q[i] <= '0;
			end
		end else if (adv) begin
			sbb_q[0] <= sbb_in;
			for (int i = 1; i < DIV_LAT; i++) begin
				sbb_q[i] <= sbb_q[i-1];
			end
		end
	end

	assign sbb_o = sbb_q[DIV_LAT-1];

	// Stage 9: vertex and its halving toward zero.
	logic v_s9, coin_s9, eq_s9, nomax_s9;
	logic signed [X0W-1:0] x0_s9, x0_c;
	logic signed [XW-1:0]  alt_s9, fb2_s9;
	logic signed [FBW-1:0] fb3_s9;
	logic [WMW-1:0]        wm;
	logic signed [VW-1:0]  vsum, vadj;
	logic signed [DXW-1:0] asum, aadj;

	always_comb begin
		wm   = (ovfc || (qc > W_CAP)) ? WMW'(W_CAP) : WMW'(qc);
		// A negative offset adds its magnitude to x1 + x2.
		vsum = sbb_o.neg ? VW'(sbb_o.sum12) + $signed(VW'(wm))
			: VW'(sbb_o.sum12) - $signed(VW'(wm));
		vadj = vsum + $signed(VW'(vsum[VW-1]));
		x0_c = X0W'(vadj >>> 1);
		asum = DXW'(sbb_o.x1) + DXW'(lower_bound_q);
		aadj = asum + $signed(DXW'(asum[DXW-1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= sbb_o.v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coin_s9  <= sbb_o.coin;
			eq_s9    <= sbb_o.eq;
			nomax_s9 <= sbb_o.nomax;
			x0_s9    <= x0_c;
			alt_s9   <= XW'(aadj >>> 1);
			fb2_s9   <= sbb_o.fb2;
			fb3_s9   <= sbb_o.fb3;
		end
	end

	// Stage 10: bound check, case selection, saturation and output register.
	logic [1:0]           outcome_c, outcome_s10;
	logic signed [XW-1:0] next_x_c, next_x_s10;
	logic                 below_c;

	assign below_c = x0_s9 < X0W'(lower_bound_q);

	always_comb begin
		if (coin_s9) begin
			outcome_c = OC_NOMAX;
		end else if (eq_s9) begin
			outcome_c = OC_EQUAL;
		end else if (nomax_s9) begin
			outcome_c = OC_NOMAX;
		end else if (below_c) begin
			outcome_c = OC_CLAMP;
		end else begin
			outcome_c = OC_VERTEX;
		end
		case (outcome_c)
			OC_NOMAX: next_x_c = sat_x(X0W'(fb3_s9));
			OC_EQUAL: next_x_c = fb2_s9;
			OC_CLAMP: next_x_c = alt_s9;
			default:  next_x_c = sat_x(x0_s9);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			outcome_s10 <= outcome_c;
			next_x_s10  <= next_x_c;
		end
	end

	assign m_tvalid = v_s10;
	assign m_tdata  = OUT_W'({outcome_s10, next_x_s10});

	// Checks on the pipeline control and the case priority.
	`PVE_ASSERT_NXT(a_in_to_s1, s_tvalid && s_tready, v_s1, "accepted item did not reach stage 1")
	`PVE_ASSERT_NXT(a_coin_nomax, adv && v_s9 && coin_s9, outcome_s10 == OC_NOMAX, "coinciding x not reported as no maximum")
	`PVE_ASSERT_NXT(a_eq_equal, adv && v_s9 && !coin_s9 && eq_s9, outcome_s10 == OC_EQUAL, "equal slopes not reported")
	`PVE_ASSERT_IMP(a_ready_rule, 1'b1, s_tready == (!m_tvalid || m_tready), "input ready does not follow output stall")
	`PVE_ASSERT_IMP(a_slope_fit, sba_o.v && !sba_o.coin, !ovfa && !ovfb, "slope quotient out of range")

endmodule

@@ rtl/pve_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on pve_pkg for its widths.
module pve_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [pve_pkg::DIV_NW-1:0] num,
	input  logic [pve_pkg::DIV_DW-1:0] den,
	output logic [pve_pkg::DIV_QW-1:0] quo,
	output logic                        ovf
);
	import pve_pkg::*;

	logic [DIV_DW-1:0] rem_q [0:DIV_QW-1];
	logic [DIV_QW-1:0] low_q [0:DIV_QW-1];
	logic [DIV_DW-1:0] den_q [0:DIV_QW-1];
	logic [DIV_QW-1:0] quo_q [0:DIV_QW];
	logic              ovf_q [1:DIV_QW];

	// Input stage: upper numerator bits seed the partial remainder.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= DIV_DW'(num >> DIV_QW);
			low_q[0] <= num[DIV_QW-1:0];
			den_q[0] <= den;
			quo_q[0] <= '0;
		end
	end

	// One compare-and-subtract per stage.
	for (genvar k = 1; k <= DIV_QW; k++) begin : g_stage
		logic [DIV_DW:0] trial;
		logic [DIV_DW:0] diff;
		logic            ge;

		assign trial = {rem_q[k-1], low_q[k-1][DIV_QW-1]};
		assign diff  = trial - {1'b0, den_q[k-1]};
		assign ge    = trial >= {1'b0, den_q[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[k] <= {quo_q[k-1][DIV_QW-2:0], ge};
			end
		end

		if (k < DIV_QW) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
					low_q[k] <= low_q[k-1] << 1;
					den_q[k] <= den_q[k-1];
				end
			end
		end

		// The quotient does not fit when the seed already reaches the divisor.
		if (k == 1) begin : g_ovf_first
			always_ff @(posedge clk) begin
				if (en) begin
					ovf_q[k] <= rem_q[0] >= den_q[0];
				end
			end
		end else begin : g_ovf_pass
			always_ff @(posedge clk) begin
				if (en) begin
					ovf_q[k] <= ovf_q[k-1];
				end
			end
		end
	end

	assign quo = quo_q[DIV_QW];
	assign ovf = ovf_q[DIV_QW];

endmodule
